// ----- hw/rtl/lsfrc_pkg.sv -----
// Package for the LED shelf fade and rainbow controller.
// Holds the opcode, register index and sequencer state codes, widths and reset values.
// No dependencies; lsfrc_fade and the top level import it.
package lsfrc_pkg;

  localparam int STRIPS    = 4;
  localparam int STRIP_W   = 2;
  localparam int FADE_STEP = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [9:0]  FRAME_PERIOD_RST = 10'd16;
  localparam logic [15:0] STARTUP_RST      = 16'd100;
  localparam logic [15:0] SHUTDOWN_RST     = 16'd10000;
  localparam logic [7:0]  COUNT0_RST       = 8'd95;
  localparam logic [7:0]  COUNT1_RST       = 8'd95;
  localparam logic [7:0]  COUNT2_RST       = 8'd96;
  localparam logic [7:0]  COUNT3_RST       = 8'd82;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SWITCH = 3'd1,
    OP_TARGET = 3'd2,
    OP_COLOR  = 3'd3,
    OP_EFFECT = 3'd4,
    OP_QUERY  = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_PERIOD = 3'd0,
    REG_STARTUP      = 3'd1,
    REG_SHUTDOWN     = 3'd2,
    REG_COUNT0       = 3'd3,
    REG_COUNT1       = 3'd4,
    REG_COUNT2       = 3'd5,
    REG_COUNT3       = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIME,
    ST_RELAY,
    ST_FRAME,
    ST_FADE,
    ST_CMD,
    ST_DIVWAIT,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic cmd_ready;
    logic do_time;
    logic do_relay;
    logic do_frame;
    logic do_fade;
    logic div_start;
    logic do_load;
  } ctrl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

// ----- hw/rtl/lsfrc_if.sv -----
// Valid/ready channel interfaces for the command and response beats.
// Depends on nothing; used by the top level of the controller.
interface lsfrc_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [1:0] strip;
  logic [7:0] pixel_index;
  logic [7:0] level;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, opcode, strip, pixel_index, level, red_in, green_in,
                  blue_in, input ready);
  modport sink (input valid, opcode, strip, pixel_index, level, red_in, green_in,
                blue_in, output ready);
endinterface

interface lsfrc_rsp_if;
  logic       valid;
  logic       ready;
  logic       relay_on;
  logic       supply_ready;
  logic       frame_done;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       pixel_valid;
  logic [7:0] strip_brightness;
  logic       strip_active;

  modport source (output valid, relay_on, supply_ready, frame_done, pixel_red, pixel_green,
                  pixel_blue, pixel_valid, strip_brightness, strip_active, input ready);
  modport sink (input valid, relay_on, supply_ready, frame_done, pixel_red, pixel_green,
                pixel_blue, pixel_valid, strip_brightness, strip_active, output ready);
endinterface

// ----- hw/rtl/lsfrc_fade.sv -----
// Shared fade unit: one strip's brightness step toward its target or toward zero.
// Depends on lsfrc_pkg for the fade step; the sequencer feeds it one strip per cycle.
module lsfrc_fade (
  input  logic       enabled,
  input  logic       lit,
  input  logic [7:0] cur,
  input  logic [7:0] tgt,
  output logic       lit_next,
  output logic [7:0] cur_next
);
  import lsfrc_pkg::*;

  localparam logic [8:0] STEP = 9'(FADE_STEP);

  logic [7:0] b;
  logic       up_ok;
  logic       dn_ok;

  // A strip that turns on starts its fade from zero.
  assign b     = (enabled && !lit) ? 8'd0 : cur;
  assign up_ok = ({1'b0, b} + STEP) <= {1'b0, tgt};
  assign dn_ok = ({1'b0, tgt} + STEP) <= {1'b0, b};

  always_comb begin
    lit_next = lit | enabled;
    cur_next = b;
    if (enabled && b != tgt) begin
      if (up_ok) begin
        cur_next = 8'({1'b0, b} + STEP);
      end else if (dn_ok) begin
        cur_next = 8'({1'b0, b} - STEP);
      end else begin
        cur_next = tgt;
      end
    end else if (!enabled && b != 8'd0) begin
      cur_next = ({1'b0, b} >= STEP) ? 8'({1'b0, b} - STEP) : 8'd0;
    end else if (!enabled && b == 8'd0 && lit) begin
      lit_next = 1'b0;
    end
  end

endmodule

// ----- hw/rtl/lsfrc_div.sv -----
// Radix-2 restoring divider for index*256/count, one quotient bit per cycle.
// Depends on nothing; the dividend must be below the divisor so the quotient fits 8 bits.
module lsfrc_div (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] quotient
);

  logic       busy;
  logic [2:0] cnt;
  logic [7:0] rem;
  logic [8:0] shifted;
  logic       ge;

  assign shifted = {rem, 1'b0};
  assign ge      = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 3'd7) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // The remainder starts as the index itself; eight zero bits are shifted in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      quotient <= 8'd0;
      cnt      <= 3'd0;
    end else if (busy) begin
      rem      <= ge ? 8'(shifted - {1'b0, divisor}) : shifted[7:0];
      quotient <= {quotient[6:0], ge};
      cnt      <= cnt + 3'd1;
    end
  end

endmodule

// ----- hw/rtl/led_shelf_fade_rainbow_ctrl.sv -----
// Top level of the LED shelf controller: relay sequencing, frame fades, pixel queries.
// Depends on lsfrc_pkg, lsfrc_if, lsfrc_fade and lsfrc_div.
// Steps: a command passes the command and load states; a tick passes time, relay, frame,
// the fade walk if a frame is due (one strip a cycle through the fade unit) and load; a
// rainbow query waits on the divider (8 steps). One item at a time: the next is taken in
// the idle state after the load, while the last response waits in its output register.
// Synchronous reset restores configuration, state and every strip to power-up values.
module led_shelf_fade_rainbow_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lsfrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsfrc_pkg::CFG_DAT_W-1:0] cfg_data,
  lsfrc_cmd_if.sink                       cmd,
  lsfrc_rsp_if.source                     rsp
);
  import lsfrc_pkg::*;

  // Configuration registers.
  logic [9:0]  frame_period;
  logic [15:0] startup_delay;
  logic [15:0] shutdown_delay;
  logic [7:0]  led_count [STRIPS];

  // Latched command.
  op_t              op;
  logic [STRIP_W-1:0] s;
  logic [7:0]       pix;
  logic [7:0]       lvl;
  rgb_t             color_in;

  // Block state.
  logic [31:0] time_ms;
  logic [31:0] relay_deadline;
  logic [31:0] next_frame_time;
  logic        relay_state;
  logic        ready_flag;
  logic [7:0]  rainbow_phase;
  logic [STRIPS-1:0] enabled;
  logic [STRIPS-1:0] lit;
  logic [STRIPS-1:0] effect;
  logic [7:0]  tgt [STRIPS];
  logic [7:0]  cur [STRIPS];
  rgb_t        color [STRIPS];
  logic        frame_flag;
  logic [STRIP_W-1:0] strip_cnt;

  state_t state;
  state_t state_next;
  ctrl_t  ctrl;

  // Output register.
  logic out_valid;

  // Pixel query signals.
  logic [7:0] count_s;
  logic       pix_in_range;
  logic       query_div;
  logic       div_done;
  logic [7:0] quotient;

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          state_next = (op_t'(cmd.opcode) == OP_TICK) ? ST_TIME : ST_CMD;
        end
      end
      ST_TIME:  state_next = ST_RELAY;
      ST_RELAY: state_next = ST_FRAME;
      ST_FRAME: begin
        state_next = (ready_flag && time_ms > next_frame_time) ? ST_FADE : ST_LOAD;
      end
      ST_FADE: begin
        if (strip_cnt == STRIP_W'(STRIPS - 1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_CMD:     state_next = query_div ? ST_DIVWAIT : ST_LOAD;
      ST_DIVWAIT: state_next = div_done ? ST_LOAD : ST_DIVWAIT;
      ST_LOAD: begin
        if (!out_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: control outputs.
  always_comb begin
    ctrl = '0;
    case (state)
      ST_IDLE:  ctrl.cmd_ready = 1'b1;
      ST_TIME:  ctrl.do_time   = 1'b1;
      ST_RELAY: ctrl.do_relay  = 1'b1;
      ST_FRAME: ctrl.do_frame  = 1'b1;
      ST_FADE:  ctrl.do_fade   = 1'b1;
      ST_CMD:   ctrl.div_start = query_div;
      ST_LOAD:  ctrl.do_load   = !out_valid || rsp.ready;
      default:  ctrl = '0;
    endcase
  end

  assign cmd.ready = ctrl.cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period   <= FRAME_PERIOD_RST;
      startup_delay  <= STARTUP_RST;
      shutdown_delay <= SHUTDOWN_RST;
      led_count[0]   <= COUNT0_RST;
      led_count[1]   <= COUNT1_RST;
      led_count[2]   <= COUNT2_RST;
      led_count[3]   <= COUNT3_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FRAME_PERIOD: frame_period   <= cfg_data[9:0];
        REG_STARTUP:      startup_delay  <= cfg_data;
        REG_SHUTDOWN:     shutdown_delay <= cfg_data;
        REG_COUNT0:       led_count[0]   <= cfg_data[7:0];
        REG_COUNT1:       led_count[1]   <= cfg_data[7:0];
        REG_COUNT2:       led_count[2]   <= cfg_data[7:0];
        REG_COUNT3:       led_count[3]   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Command latch.
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op             <= op_t'(cmd.opcode);
      s              <= cmd.strip;
      pix            <= cmd.pixel_index;
      lvl            <= cmd.level;
      color_in.red   <= cmd.red_in;
      color_in.green <= cmd.green_in;
      color_in.blue  <= cmd.blue_in;
    end
  end

  // Pixel query decode.
  assign count_s      = led_count[s];
  assign pix_in_range = pix < count_s;
  assign query_div    = (op == OP_QUERY) && effect[s] && pix_in_range;

  lsfrc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (pix),
    .divisor  (count_s),
    .done     (div_done),
    .quotient (quotient)
  );

  // Relay sequencing, evaluated once time_ms has advanced.
  logic        should;
  logic        dl_passed;
  logic [31:0] dl_sum;
  logic [31:0] dl_next;
  logic        rs_next;
  logic        rf_next;

  assign should    = |enabled;
  assign dl_passed = time_ms > relay_deadline;
  assign dl_sum    = time_ms + {16'd0, should ? startup_delay : shutdown_delay};

  always_comb begin
    dl_next = relay_deadline;
    rs_next = relay_state;
    rf_next = ready_flag;
    if (should && !ready_flag) begin
      if (!relay_state) begin
        rs_next = 1'b1;
        rf_next = 1'b0;
        dl_next = dl_sum;
      end else if (dl_passed) begin
        rf_next = 1'b1;
        dl_next = 32'd0;
      end
    end
    if (!should && relay_state) begin
      if (relay_deadline == 32'd0) begin
        dl_next = dl_sum;
      end else if (dl_passed) begin
        dl_next = 32'd0;
        rs_next = 1'b0;
        rf_next = 1'b0;
      end
    end
    // A ready supply with strips on keeps no deadline armed.
    if (should && rf_next) begin
      dl_next = 32'd0;
    end
  end

  // Per-strip arrays are read at one index: the fade walk or the addressed strip.
  logic [STRIP_W-1:0] idx;
  logic               fade_lit;
  logic [7:0]         fade_cur;

  assign idx = ctrl.do_fade ? strip_cnt : s;

  lsfrc_fade u_fade (
    .enabled  (enabled[idx]),
    .lit      (lit[idx]),
    .cur      (cur[idx]),
    .tgt      (tgt[idx]),
    .lit_next (fade_lit),
    .cur_next (fade_cur)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms         <= 32'd0;
      relay_deadline  <= 32'd0;
      next_frame_time <= 32'd0;
      relay_state     <= 1'b0;
      ready_flag      <= 1'b0;
      rainbow_phase   <= 8'd0;
      frame_flag      <= 1'b0;
      strip_cnt       <= '0;
      enabled         <= '0;
      lit             <= '0;
      effect          <= '0;
      for (int i = 0; i < STRIPS; i++) begin
        tgt[i]   <= 8'd255;
        cur[i]   <= 8'd0;
        color[i] <= '{red: 8'd255, green: 8'd255, blue: 8'd255};
      end
    end else begin
      if (ctrl.cmd_ready) begin
        frame_flag <= 1'b0;
      end
      if (ctrl.do_time) begin
        time_ms <= time_ms + 32'd1;
      end
      if (ctrl.do_relay) begin
        relay_deadline <= dl_next;
        relay_state    <= rs_next;
        ready_flag     <= rf_next;
      end
      if (ctrl.do_frame && ready_flag && time_ms > next_frame_time) begin
        rainbow_phase   <= rainbow_phase - 8'd1;
        next_frame_time <= time_ms + {22'd0, frame_period};
        frame_flag      <= 1'b1;
        strip_cnt       <= '0;
      end
      if (ctrl.do_fade) begin
        cur[idx]  <= fade_cur;
        lit[idx]  <= fade_lit;
        strip_cnt <= strip_cnt + STRIP_W'(1);
      end
      if (ctrl.do_load) begin
        case (op)
          OP_SWITCH: enabled[s] <= lvl[0];
          OP_TARGET: tgt[s]     <= lvl;
          OP_COLOR:  color[s]   <= color_in;
          OP_EFFECT: effect[s]  <= (lvl == 8'd1);
          default: ;
        endcase
      end
    end
  end

  // Color wheel: three ramps over the inverted position.
  function automatic rgb_t wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] p3;
    rgb_t       c;
    p = ~pos;
    c = '0;
    if (p < 8'd85) begin
      p3 = 8'({1'b0, p} * 9'd3);
      c  = '{red: 8'd255 - p3, green: 8'd0, blue: p3};
    end else if (p < 8'd170) begin
      p3 = 8'({1'b0, p - 8'd85} * 9'd3);
      c  = '{red: 8'd0, green: p3, blue: 8'd255 - p3};
    end else begin
      p3 = 8'({1'b0, p - 8'd170} * 9'd3);
      c  = '{red: p3, green: 8'd255 - p3, blue: 8'd0};
    end
    return c;
  endfunction

  logic is_query;
  logic pix_ok;
  rgb_t pix_rgb;

  assign is_query = (op == OP_QUERY);
  assign pix_ok   = is_query && pix_in_range;

  always_comb begin
    pix_rgb = '0;
    if (pix_ok) begin
      if (effect[s]) begin
        pix_rgb = wheel(quotient + rainbow_phase);
      end else begin
        // Stored order has its first two channels swapped on the way out.
        pix_rgb = '{red: color[s].green, green: color[s].red, blue: color[s].blue};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.do_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.do_load) begin
      rsp.relay_on         <= relay_state;
      rsp.supply_ready     <= ready_flag;
      rsp.frame_done       <= frame_flag && (op == OP_TICK);
      rsp.pixel_red        <= pix_rgb.red;
      rsp.pixel_green      <= pix_rgb.green;
      rsp.pixel_blue       <= pix_rgb.blue;
      rsp.pixel_valid      <= pix_ok;
      rsp.strip_brightness <= cur[idx];
      rsp.strip_active     <= lit[idx];
    end
  end

  assign rsp.valid = out_valid;

endmodule
